// ===== hdl/tlp_pkg.sv =====
// Shared constants, types and helper functions for the text line packager.
`default_nettype none

package tlp_pkg;

  // Store depth default and fixed field widths.
  localparam int unsigned MAX_LINE_DEF = 250;
  localparam int unsigned FILL_W       = 8;
  localparam int unsigned BEAT_BYTES   = 8;
  localparam int unsigned BEAT_W       = 8 * BEAT_BYTES;
  localparam int unsigned CNT_W        = 4;

  // Reset value of the line limit register.
  localparam logic [7:0] LIMIT_RESET = 8'd250;

  // Character codes used in the packaged line.
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_LC  = 8'h61;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the input byte into the line store
    logic start;       // begin replaying the line
    logic term_slash;  // terminator is '/' rather than '<'
    logic advance;     // emit the current line byte
  } tlp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_zero;    // line store is empty
    logic is_lf;        // input byte is a line feed
    logic store_flush;  // storing this byte reaches the limit, or a whitespace byte comes one short of it
    logic beat_end;     // current byte closes an output word
    logic line_end;     // current byte is the final line feed
    logic out_free;     // output register can take a word this cycle
  } tlp_stat_t;

  // C-locale whitespace test.
  function automatic logic is_c_space(input logic [7:0] b);
    return (b == CHAR_SP) || ((b >= CHAR_HT) && (b <= CHAR_CR));
  endfunction

  // One lowercase hex digit for a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] res;
    if (v < 4'd10) begin
      res = CHAR_ZERO + {4'd0, v};
    end else begin
      res = CHAR_A_LC + {4'd0, v} - 8'd10;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/text_line_packager_core.sv =====
// Top level of the text line packager: controller plus datapath.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_byte_in, in_end_of_text
//   out_     output     out_valid / out_ready  out_bytes, out_byte_count, out_last
//   cfg_     input      cfg_valid / cfg_ready  cfg_data (line limit)
//
// A byte that is stored without a break keeps in_ready high for the byte after it.
// A line of n stored bytes replays as n+4 line bytes, one line byte per cycle from the
// single read port of the line store while the output side does not stall.
// No input byte is taken during replay; the last output word may wait while new bytes store.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
`default_nettype none

module text_line_packager_core #(
  parameter int unsigned MAX_LINE = tlp_pkg::MAX_LINE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte_in,
  input  wire logic                  in_end_of_text,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [tlp_pkg::BEAT_W-1:0] out_bytes,
  output logic [tlp_pkg::CNT_W-1:0]  out_byte_count,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_data
);
  import tlp_pkg::*;

  tlp_cmd_t  cmd;
  tlp_stat_t stat;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  tlp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_end_of_text (in_end_of_text),
    .stat           (stat),
    .cmd            (cmd)
  );

  tlp_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte_in     (in_byte_in),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ===== hdl/tlp_datapath.sv =====
// Line store, fill counter, line replay and output word register.
`default_nettype none

module tlp_datapath #(
  parameter int unsigned MAX_LINE = tlp_pkg::MAX_LINE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [7:0]               in_byte_in,
  input  wire logic                     cfg_valid,
  input  wire logic [7:0]               cfg_data,
  input  wire tlp_pkg::tlp_cmd_t        cmd,
  output tlp_pkg::tlp_stat_t            stat,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [tlp_pkg::BEAT_W-1:0]    out_bytes,
  output logic [tlp_pkg::CNT_W-1:0]     out_byte_count,
  output logic                          out_last
);
  import tlp_pkg::*;

  localparam int unsigned AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_LINE);

  // Line store, written at the fill count and read one byte per cycle during replay.
  logic [7:0] mem [MAX_LINE];

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        limit_r;
  logic [7:0]        term_r;
  logic [FILL_W-1:0] pos_r, pos_nxt;
  logic [7:0]        rd_data_r;
  logic [BEAT_W-1:0] asm_r;
  logic [2:0]        asm_cnt_r;
  logic              out_valid_r;
  logic [BEAT_W-1:0] out_bytes_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_last_r;

  logic [FILL_W-1:0] limit_eff;
  logic              store_full;
  logic              store_we;
  logic [FILL_W:0]   fill_inc;
  logic [FILL_W:0]   flush_test;
  logic [FILL_W-1:0] rd_idx;
  logic              rd_en;
  logic              line_end;
  logic              beat_end;
  logic              out_free;
  logic [7:0]        cur_byte;
  logic [BEAT_W-1:0] asm_merged;

  // Limit in effect and the forced-break test for a stored byte.
  always_comb begin
    limit_eff  = (limit_r > MAX_FILL) ? MAX_FILL : limit_r;
    store_full = (fill_r >= MAX_FILL);
    store_we   = cmd.store && !store_full;
    fill_inc   = {1'b0, fill_r} + {{FILL_W{1'b0}}, !store_full};
    flush_test = fill_inc + {{FILL_W{1'b0}}, is_c_space(in_byte_in)};
  end

  // Replay position and the store address that it needs next.
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.start) begin
      pos_nxt = '0;
    end else if (cmd.advance) begin
      pos_nxt = pos_r + 1'b1;
    end
    rd_idx = pos_nxt - FILL_W'(2);
    rd_en  = (pos_nxt >= FILL_W'(2)) && (rd_idx < fill_r);
  end

  // Current line byte: two hex digits, stored bytes, terminator, line feed.
  always_comb begin
    line_end = (pos_r == fill_r + FILL_W'(3));
    beat_end = (asm_cnt_r == 3'd7) || line_end;
    out_free = !out_valid_r || out_ready;
    if (pos_r == '0) begin
      cur_byte = hex_digit(fill_r[7:4]);
    end else if (pos_r == FILL_W'(1)) begin
      cur_byte = hex_digit(fill_r[3:0]);
    end else if (pos_r == fill_r + FILL_W'(2)) begin
      cur_byte = term_r;
    end else if (line_end) begin
      cur_byte = CHAR_LF;
    end else begin
      cur_byte = rd_data_r;
    end
    asm_merged = asm_r;
    for (int i = 0; i < BEAT_BYTES; i++) begin
      if (asm_cnt_r == 3'(i)) begin
        asm_merged[8*i +: 8] = cur_byte;
      end
    end
  end

  // Fill count next value.
  always_comb begin
    fill_nxt = fill_r;
    if (store_we) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.advance && line_end) begin
      fill_nxt = '0;
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (store_we) begin
      mem[fill_r[AW-1:0]] <= in_byte_in;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      limit_r     <= LIMIT_RESET;
      pos_r       <= '0;
      asm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (cmd.start || (cmd.advance && beat_end)) begin
        asm_cnt_r <= '0;
      end else if (cmd.advance) begin
        asm_cnt_r <= asm_cnt_r + 1'b1;
      end
      if (cmd.advance && beat_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Word assembly and output payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      term_r <= cmd.term_slash ? CHAR_SLASH : CHAR_LT;
    end
    if (cmd.start || (cmd.advance && beat_end)) begin
      asm_r <= '0;
    end else if (cmd.advance) begin
      asm_r <= asm_merged;
    end
    if (cmd.advance && beat_end) begin
      out_bytes_r <= asm_merged;
      out_count_r <= {1'b0, asm_cnt_r} + 1'b1;
      out_last_r  <= line_end;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.fill_zero   = (fill_r == '0);
    stat.is_lf       = (in_byte_in == CHAR_LF);
    stat.store_flush = (flush_test >= {1'b0, limit_eff});
    stat.beat_end    = beat_end;
    stat.line_end    = line_end;
    stat.out_free    = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_count_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/tlp_ctrl.sv =====
// Controller state machine: accepts input bytes, starts and paces line replay.
`default_nettype none

module tlp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_end_of_text,
  input  wire tlp_pkg::tlp_stat_t stat,
  output tlp_pkg::tlp_cmd_t       cmd
);
  import tlp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          if (in_end_of_text) begin
            if (!stat.fill_zero) begin
              cmd.start      = 1'b1;
              cmd.term_slash = 1'b1;
              state_nxt      = ST_FLUSH;
            end
          end else if (stat.is_lf) begin
            cmd.start = 1'b1;
            state_nxt = ST_FLUSH;
          end else begin
            cmd.store = 1'b1;
            if (stat.store_flush) begin
              cmd.start      = 1'b1;
              cmd.term_slash = 1'b1;
              state_nxt      = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        // A byte that closes a word waits for room in the output register.
        cmd.advance = !stat.beat_end || stat.out_free;
        if (cmd.advance && stat.line_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlp_checker.sv =====
// Port-level checker for the text line packager and its bind.
`default_nettype none

module tlp_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [tlp_pkg::BEAT_W-1:0] out_bytes,
  input wire logic [tlp_pkg::CNT_W-1:0]  out_byte_count,
  input wire logic                  out_last
);
  import tlp_pkg::*;

  // A stalled word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes) &&
    $stable(out_byte_count) && $stable(out_last))
    else $error("output word changed while stalled");

  // Every word carries one to eight bytes.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != '0) && (out_byte_count <= CNT_W'(BEAT_BYTES)))
    else $error("byte count out of range");

  // Only the closing word of a line may be short.
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte_count == CNT_W'(BEAT_BYTES))
    else $error("short word before end of line");

  // The closing word ends in a line feed.
  a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (out_byte_count != '0) |->
    (out_bytes >> (8 * (out_byte_count - 1'b1))) % 256 == BEAT_W'(CHAR_LF))
    else $error("closing word does not end in a line feed");

endmodule

bind text_line_packager_core tlp_checker u_tlp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_bytes      (out_bytes),
  .out_byte_count (out_byte_count),
  .out_last       (out_last)
);

`default_nettype wire
